>>> hw/rtl/ptnm_pkg.sv
// Shared types and constants for the point-to-triangle nearest search.
// Used by every module of the block; no dependencies of its own.
package ptnm_pkg;

    localparam int COORD_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int DOT_W    = 2 * EDGE_W + 2 - FRAC_W;
    localparam int MUL_W    = DOT_W;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int SQ_W     = 2 * COORD_W + 2 - FRAC_W;
    localparam int DIST_W   = COORD_W + 1;
    localparam int Q_W      = FRAC_W + 1;
    localparam int ROOT_ARG_W = SQ_W + FRAC_W;
    localparam int STEP_W   = 5;
    localparam int IDX_W    = 2;
    localparam int DIV_CNT_W = $clog2(FRAC_W + 1);

    localparam logic [Q_W-1:0]  ONE_Q  = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};
    localparam logic [ROOT_ARG_W-1:0] ROOT_TOP = ROOT_ARG_W'(1) << (2 * (DIST_W - 1));

    localparam logic [IDX_W-1:0] REG_QUERY_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_QUERY_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_QUERY_Z = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;

    // A classified triangle: base vertex, edges e1 and e2, base minus query.
    typedef struct packed {
        coord_t [2:0] v0;
        edge_t  [2:0] e1;
        edge_t  [2:0] e2;
        edge_t  [2:0] bp;
        logic         last;
    } item_t;

endpackage

>>> hw/rtl/point_triangle_nearest_min.sv
// Nearest mesh point to a query point. Load the query into registers 0..2, then stream
// triangles; the back end works on each with one shared multiplier (30 products) and a
// one-bit-per-cycle divider, and the last triangle of a scan adds a square root.
// A two-entry queue lets the front accept up to two triangles ahead of the back end.
// Depends on ptnm_pkg, ptnm_front, ptnm_queue and ptnm_back.
module point_triangle_nearest_min (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [ptnm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ptnm_pkg::COORD_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  ptnm_pkg::coord_t corner0_x,
    input  ptnm_pkg::coord_t corner0_y,
    input  ptnm_pkg::coord_t corner0_z,
    input  ptnm_pkg::coord_t corner1_x,
    input  ptnm_pkg::coord_t corner1_y,
    input  ptnm_pkg::coord_t corner1_z,
    input  ptnm_pkg::coord_t corner2_x,
    input  ptnm_pkg::coord_t corner2_y,
    input  ptnm_pkg::coord_t corner2_z,
    input  logic             last_triangle,
    output logic             out_valid,
    input  logic             out_stall,
    output ptnm_pkg::coord_t nearest_x,
    output ptnm_pkg::coord_t nearest_y,
    output ptnm_pkg::coord_t nearest_z,
    output logic [ptnm_pkg::SQ_W-1:0]   squared_distance,
    output logic [ptnm_pkg::DIST_W-1:0] distance
);
    import ptnm_pkg::*;

    coord_t query_x_reg, query_y_reg, query_z_reg;
    logic   q_full, q_push, q_valid, q_pop;
    item_t  q_in, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= '0;
            query_y_reg <= '0;
            query_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUERY_X: query_x_reg <= cfg_data;
                REG_QUERY_Y: query_y_reg <= cfg_data;
                REG_QUERY_Z: query_z_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ptnm_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .corner0_x     (corner0_x),
        .corner0_y     (corner0_y),
        .corner0_z     (corner0_z),
        .corner1_x     (corner1_x),
        .corner1_y     (corner1_y),
        .corner1_z     (corner1_z),
        .corner2_x     (corner2_x),
        .corner2_y     (corner2_y),
        .corner2_z     (corner2_z),
        .last_triangle (last_triangle),
        .query_x       (query_x_reg),
        .query_y       (query_y_reg),
        .query_z       (query_z_reg),
        .full          (q_full),
        .push          (q_push),
        .push_item     (q_in)
    );

    ptnm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    ptnm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_item           (q_head),
        .q_pop            (q_pop),
        .query_x          (query_x_reg),
        .query_y          (query_y_reg),
        .query_z          (query_z_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .nearest_x        (nearest_x),
        .nearest_y        (nearest_y),
        .nearest_z        (nearest_z),
        .squared_distance (squared_distance),
        .distance         (distance)
    );

endmodule

>>> hw/rtl/ptnm_front.sv
// Front end: takes a triangle, forms edges and base offset, pushes the item.
// Depends on ptnm_pkg.
module ptnm_front (
    input  logic            in_valid,
    output logic            in_stall,
    input  ptnm_pkg::coord_t corner0_x,
    input  ptnm_pkg::coord_t corner0_y,
    input  ptnm_pkg::coord_t corner0_z,
    input  ptnm_pkg::coord_t corner1_x,
    input  ptnm_pkg::coord_t corner1_y,
    input  ptnm_pkg::coord_t corner1_z,
    input  ptnm_pkg::coord_t corner2_x,
    input  ptnm_pkg::coord_t corner2_y,
    input  ptnm_pkg::coord_t corner2_z,
    input  logic            last_triangle,
    input  ptnm_pkg::coord_t query_x,
    input  ptnm_pkg::coord_t query_y,
    input  ptnm_pkg::coord_t query_z,
    input  logic            full,
    output logic            push,
    output ptnm_pkg::item_t push_item
);
    import ptnm_pkg::*;

    function automatic edge_t diff(input coord_t a, input coord_t b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    assign in_stall = full;
    assign push     = in_valid && !full;

    always_comb
    begin
        push_item.v0[0] = corner0_x;
        push_item.v0[1] = corner0_y;
        push_item.v0[2] = corner0_z;
        push_item.e1[0] = diff(corner1_x, corner0_x);
        push_item.e1[1] = diff(corner1_y, corner0_y);
        push_item.e1[2] = diff(corner1_z, corner0_z);
        push_item.e2[0] = diff(corner2_x, corner0_x);
        push_item.e2[1] = diff(corner2_y, corner0_y);
        push_item.e2[2] = diff(corner2_z, corner0_z);
        push_item.bp[0] = diff(corner0_x, query_x);
        push_item.bp[1] = diff(corner0_y, query_y);
        push_item.bp[2] = diff(corner0_z, query_z);
        push_item.last  = last_triangle;
    end

endmodule

>>> hw/rtl/ptnm_queue.sv
// Two-entry item queue between front end and back end.
// Depends on ptnm_pkg.
module ptnm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ptnm_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output ptnm_pkg::item_t head
);
    import ptnm_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> hw/rtl/ptnm_div.sv
// Clamped fractional divider: 0 if num <= 0, one if num >= den, else
// floor(num * 2^FRAC_W / den), one quotient bit per cycle. Depends on ptnm_pkg.
module ptnm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [ptnm_pkg::ACC_W-1:0] num,
    input  logic signed [ptnm_pkg::ACC_W-1:0] den,
    output logic                          done,
    output logic [ptnm_pkg::Q_W-1:0]      quot
);
    import ptnm_pkg::*;

    logic signed [ACC_W:0]   rem_reg;
    logic signed [ACC_W-1:0] den_reg;
    logic [Q_W-1:0]          quot_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic signed [ACC_W:0]   rem_sh;
    logic signed [ACC_W:0]   den_x;
    logic                    ge;

    assign rem_sh = rem_reg <<< 1;
    assign den_x  = {den_reg[ACC_W-1], den_reg};
    assign ge     = (rem_sh >= den_x);
    assign done   = done_reg;
    assign quot   = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                den_reg <= den;
                if (num < 1)
                begin
                    quot_reg <= '0;
                    done_reg <= 1'b1;
                end
                else if (num >= den)
                begin
                    quot_reg <= ONE_Q;
                    done_reg <= 1'b1;
                end
                else
                begin
                    rem_reg  <= {num[ACC_W-1], num};
                    quot_reg <= '0;
                    cnt_reg  <= DIV_CNT_W'(FRAC_W);
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? (rem_sh - den_x) : rem_sh;
                quot_reg <= {quot_reg[Q_W-2:0], ge};
                cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/ptnm_root.sv
// Integer square root, one result bit per cycle, by remainder and trial bit.
// Depends on ptnm_pkg.
module ptnm_root (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ptnm_pkg::ROOT_ARG_W-1:0]   arg,
    output logic                              done,
    output logic [ptnm_pkg::DIST_W-1:0]       root
);
    import ptnm_pkg::*;

    logic [ROOT_ARG_W-1:0] op_reg;
    logic [ROOT_ARG_W-1:0] res_reg;
    logic [ROOT_ARG_W-1:0] bit_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [ROOT_ARG_W:0]   trial;
    logic                  take;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign take  = ({1'b0, op_reg} >= trial);
    assign done  = done_reg;
    assign root  = res_reg[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                op_reg   <= arg;
                res_reg  <= '0;
                bit_reg  <= ROOT_TOP;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (take)
                begin
                    op_reg  <= op_reg - trial[ROOT_ARG_W-1:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg == ROOT_ARG_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/ptnm_back.sv
// Back end: sequencer over one shared multiplier for dot products, region
// choice, clamped division, nearest point, running minimum and result.
// Depends on ptnm_pkg, ptnm_div and ptnm_root.
module ptnm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  ptnm_pkg::item_t  q_item,
    output logic             q_pop,
    input  ptnm_pkg::coord_t query_x,
    input  ptnm_pkg::coord_t query_y,
    input  ptnm_pkg::coord_t query_z,
    output logic             out_valid,
    input  logic             out_stall,
    output ptnm_pkg::coord_t nearest_x,
    output ptnm_pkg::coord_t nearest_y,
    output ptnm_pkg::coord_t nearest_z,
    output logic [ptnm_pkg::SQ_W-1:0]   squared_distance,
    output logic [ptnm_pkg::DIST_W-1:0] distance
);
    import ptnm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_MAC, ST_REGION, ST_DIV_GO, ST_DIV_WAIT,
        ST_UPDATE, ST_ROOT_GO, ST_ROOT_WAIT, ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        MODE_ST, MODE_S_T0, MODE_T_S0, MODE_S_T1, MODE_T_S1
    } mode_t;

    localparam logic [STEP_W-1:0] STEP_A_END      = 5'd2;
    localparam logic [STEP_W-1:0] STEP_B_END      = 5'd5;
    localparam logic [STEP_W-1:0] STEP_C_END      = 5'd8;
    localparam logic [STEP_W-1:0] STEP_D_END      = 5'd11;
    localparam logic [STEP_W-1:0] STEP_E_END      = 5'd14;
    localparam logic [STEP_W-1:0] STEP_S_END      = 5'd16;
    localparam logic [STEP_W-1:0] STEP_T_END      = 5'd18;
    localparam logic [STEP_W-1:0] STEP_DET_END    = 5'd20;
    localparam logic [STEP_W-1:0] STEP_NEAR_FIRST = 5'd21;
    localparam logic [STEP_W-1:0] STEP_NX_END     = 5'd22;
    localparam logic [STEP_W-1:0] STEP_NY_END     = 5'd24;
    localparam logic [STEP_W-1:0] STEP_NZ_END     = 5'd26;
    localparam logic [STEP_W-1:0] STEP_DIST_END   = 5'd29;

    function automatic logic signed [MUL_W-1:0] ext_edge(input logic signed [EDGE_W-1:0] x);
        return {{(MUL_W-EDGE_W){x[EDGE_W-1]}}, x};
    endfunction

    function automatic logic signed [MUL_W-1:0] ext_q(input logic [Q_W-1:0] x);
        return {{(MUL_W-Q_W){1'b0}}, x};
    endfunction

    function automatic logic signed [ACC_W-1:0] wx(input logic signed [DOT_W-1:0] x);
        return {{(ACC_W-DOT_W){x[DOT_W-1]}}, x};
    endfunction

    state_t                  state_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    coord_t                  v0_reg [3];
    edge_t                   e1_reg [3];
    edge_t                   e2_reg [3];
    edge_t                   bp_reg [3];
    logic                    last_reg;
    logic signed [DOT_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic signed [ACC_W-1:0] s_reg, t_reg, det_reg;
    mode_t                   mode_reg;
    logic signed [ACC_W-1:0] num_reg, den_reg;
    logic                    div_second_reg;
    logic [Q_W-1:0]          r0_reg, sq_reg, tq_reg;
    coord_t                  near_reg [3];
    logic [SQ_W-1:0]         dist_reg;
    logic [SQ_W-1:0]         best_sq_reg;
    coord_t                  best_pt_reg [3];
    logic [DIST_W-1:0]       root_val_reg;
    logic                    out_valid_reg;
    coord_t                  out_pt_reg [3];
    logic [SQ_W-1:0]         out_sq_reg;
    logic [DIST_W-1:0]       out_dist_reg;

    // Operand selection for the shared multiplier
    logic [1:0]               axis;
    logic signed [MUL_W-1:0]  opa, opb;
    coord_t                   qv [3];
    edge_t                    dq [3];
    logic signed [ACC_W-1:0]  prod_x, acc_sum;
    logic                     neg;

    assign qv[0] = query_x;
    assign qv[1] = query_y;
    assign qv[2] = query_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dq[i] = {near_reg[i][COORD_W-1], near_reg[i]} - {qv[i][COORD_W-1], qv[i]};
        end
    end

    always_comb
    begin
        case (step_reg)
            5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd21, 5'd22, 5'd27: axis = 2'd0;
            5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd23, 5'd24, 5'd28: axis = 2'd1;
            default: axis = 2'd2;
        endcase
    end

    always_comb
    begin
        opa = '0;
        opb = '0;
        case (step_reg)
            5'd0, 5'd1, 5'd2:
            begin
                opa = ext_edge(e1_reg[axis]);
                opb = ext_edge(e1_reg[axis]);
            end
            5'd3, 5'd4, 5'd5:
            begin
                opa = ext_edge(e1_reg[axis]);
                opb = ext_edge(e2_reg[axis]);
            end
            5'd6, 5'd7, 5'd8:
            begin
                opa = ext_edge(e2_reg[axis]);
                opb = ext_edge(e2_reg[axis]);
            end
            5'd9, 5'd10, 5'd11:
            begin
                opa = ext_edge(e1_reg[axis]);
                opb = ext_edge(bp_reg[axis]);
            end
            5'd12, 5'd13, 5'd14:
            begin
                opa = ext_edge(e2_reg[axis]);
                opb = ext_edge(bp_reg[axis]);
            end
            5'd15: begin opa = b_reg; opb = e_reg; end
            5'd16: begin opa = c_reg; opb = d_reg; end
            5'd17: begin opa = b_reg; opb = d_reg; end
            5'd18: begin opa = a_reg; opb = e_reg; end
            5'd19: begin opa = a_reg; opb = c_reg; end
            5'd20: begin opa = b_reg; opb = b_reg; end
            5'd21, 5'd23, 5'd25:
            begin
                opa = ext_q(sq_reg);
                opb = ext_edge(e1_reg[axis]);
            end
            5'd22, 5'd24, 5'd26:
            begin
                opa = ext_q(tq_reg);
                opb = ext_edge(e2_reg[axis]);
            end
            5'd27, 5'd28, 5'd29:
            begin
                opa = ext_edge(dq[axis]);
                opb = ext_edge(dq[axis]);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign neg     = (step_reg == STEP_S_END) || (step_reg == STEP_T_END)
                  || (step_reg == STEP_DET_END);
    assign prod_x  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_sum = neg ? (acc_reg - prod_x) : (acc_reg + prod_x);

    // Region choice (seven regions) on the registered dot products
    logic signed [ACC_W-1:0] w_a, w_b, w_c, w_d, w_e;
    logic signed [ACC_W-1:0] st_sum, bd, ce, be, ad, denom;
    logic                    sneg, tneg;
    mode_t                   r_mode;
    logic signed [ACC_W-1:0] r_num, r_den;

    always_comb
    begin
        w_a    = wx(a_reg);
        w_b    = wx(b_reg);
        w_c    = wx(c_reg);
        w_d    = wx(d_reg);
        w_e    = wx(e_reg);
        st_sum = s_reg + t_reg;
        bd     = w_b + w_d;
        ce     = w_c + w_e;
        be     = w_b + w_e;
        ad     = w_a + w_d;
        denom  = w_a - w_b - w_b + w_c;
        sneg   = s_reg[ACC_W-1];
        tneg   = t_reg[ACC_W-1];
        r_mode = MODE_ST;
        r_num  = s_reg;
        r_den  = det_reg;
        if (st_sum <= det_reg)
        begin
            priority if (sneg && tneg)
            begin
                if (w_d < 0)
                begin
                    r_mode = MODE_S_T0; r_num = -w_d; r_den = w_a;
                end
                else
                begin
                    r_mode = MODE_T_S0; r_num = -w_e; r_den = w_c;
                end
            end
            else if (sneg)
            begin
                r_mode = MODE_T_S0; r_num = -w_e; r_den = w_c;
            end
            else if (tneg)
            begin
                r_mode = MODE_S_T0; r_num = -w_d; r_den = w_a;
            end
            else
            begin
                r_mode = MODE_ST; r_num = s_reg; r_den = det_reg;
            end
        end
        else if (sneg)
        begin
            if (ce > bd)
            begin
                r_mode = MODE_S_T1; r_num = ce - bd; r_den = denom;
            end
            else
            begin
                // Clamp to one: a positive numerator over zero gives one
                r_mode = MODE_T_S0;
                r_num  = (ce < 1) ? ACC_W'(1) : -w_e;
                r_den  = (ce < 1) ? '0 : w_c;
            end
        end
        else if (tneg)
        begin
            if (ad > be)
            begin
                r_mode = MODE_T_S1; r_num = ad - be; r_den = denom;
            end
            else
            begin
                r_mode = MODE_S_T0;
                r_num  = (ad < 1) ? ACC_W'(1) : -w_d;
                r_den  = (ad < 1) ? '0 : w_a;
            end
        end
        else
        begin
            r_mode = MODE_S_T1; r_num = ce - bd; r_den = denom;
        end
    end

    // Divider and square root units
    logic                    div_start, div_done;
    logic signed [ACC_W-1:0] div_num, div_den;
    logic [Q_W-1:0]          div_quot;
    logic                    root_start, root_done;
    logic [DIST_W-1:0]       root_out;

    assign div_start  = (state_reg == ST_DIV_GO);
    assign div_num    = div_second_reg ? t_reg : num_reg;
    assign div_den    = div_second_reg ? det_reg : den_reg;
    assign root_start = (state_reg == ST_ROOT_GO);

    ptnm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    ptnm_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .arg   ({best_sq_reg, {FRAC_W{1'b0}}}),
        .done  (root_done),
        .root  (root_out)
    );

    assign q_pop            = (state_reg == ST_IDLE) && q_valid;
    assign out_valid        = out_valid_reg;
    assign nearest_x        = out_pt_reg[0];
    assign nearest_y        = out_pt_reg[1];
    assign nearest_z        = out_pt_reg[2];
    assign squared_distance = out_sq_reg;
    assign distance         = out_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            acc_reg        <= '0;
            prod_reg       <= '0;
            last_reg       <= 1'b0;
            a_reg          <= '0;
            b_reg          <= '0;
            c_reg          <= '0;
            d_reg          <= '0;
            e_reg          <= '0;
            s_reg          <= '0;
            t_reg          <= '0;
            det_reg        <= '0;
            mode_reg       <= MODE_ST;
            num_reg        <= '0;
            den_reg        <= '0;
            div_second_reg <= 1'b0;
            r0_reg         <= '0;
            sq_reg         <= '0;
            tq_reg         <= '0;
            dist_reg       <= '0;
            best_sq_reg    <= SQ_MAX;
            root_val_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_sq_reg     <= '0;
            out_dist_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                v0_reg[i]      <= '0;
                e1_reg[i]      <= '0;
                e2_reg[i]      <= '0;
                bp_reg[i]      <= '0;
                near_reg[i]    <= '0;
                best_pt_reg[i] <= '0;
                out_pt_reg[i]  <= '0;
            end
        end
        else
        begin
            // Drop the result once taken, unless a new one replaces it now
            if (out_valid_reg && !out_stall && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            v0_reg[i] <= q_item.v0[i];
                            e1_reg[i] <= q_item.e1[i];
                            e2_reg[i] <= q_item.e2[i];
                            bp_reg[i] <= q_item.bp[i];
                        end
                        last_reg  <= q_item.last;
                        step_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= opa * opb;
                    state_reg <= ST_MAC;
                end
                ST_MAC:
                begin
                    acc_reg   <= acc_sum;
                    step_reg  <= step_reg + STEP_W'(1);
                    state_reg <= ST_MUL;
                    unique case (step_reg)
                        STEP_A_END:
                        begin
                            a_reg <= acc_sum[FRAC_W +: DOT_W]; acc_reg <= '0;
                        end
                        STEP_B_END:
                        begin
                            b_reg <= acc_sum[FRAC_W +: DOT_W]; acc_reg <= '0;
                        end
                        STEP_C_END:
                        begin
                            c_reg <= acc_sum[FRAC_W +: DOT_W]; acc_reg <= '0;
                        end
                        STEP_D_END:
                        begin
                            d_reg <= acc_sum[FRAC_W +: DOT_W]; acc_reg <= '0;
                        end
                        STEP_E_END:
                        begin
                            e_reg <= acc_sum[FRAC_W +: DOT_W]; acc_reg <= '0;
                        end
                        STEP_S_END:
                        begin
                            s_reg <= acc_sum; acc_reg <= '0;
                        end
                        STEP_T_END:
                        begin
                            t_reg <= acc_sum; acc_reg <= '0;
                        end
                        STEP_DET_END:
                        begin
                            det_reg   <= acc_sum;
                            acc_reg   <= '0;
                            state_reg <= ST_REGION;
                        end
                        STEP_NX_END:
                        begin
                            near_reg[0] <= v0_reg[0] + acc_sum[FRAC_W +: COORD_W];
                            acc_reg     <= '0;
                        end
                        STEP_NY_END:
                        begin
                            near_reg[1] <= v0_reg[1] + acc_sum[FRAC_W +: COORD_W];
                            acc_reg     <= '0;
                        end
                        STEP_NZ_END:
                        begin
                            near_reg[2] <= v0_reg[2] + acc_sum[FRAC_W +: COORD_W];
                            acc_reg     <= '0;
                        end
                        STEP_DIST_END:
                        begin
                            // Saturate a distance too wide for the result
                            if (|acc_sum[ACC_W-1:FRAC_W+SQ_W])
                            begin
                                dist_reg <= SQ_MAX;
                            end
                            else
                            begin
                                dist_reg <= acc_sum[FRAC_W +: SQ_W];
                            end
                            state_reg <= ST_UPDATE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_REGION:
                begin
                    mode_reg       <= r_mode;
                    num_reg        <= r_num;
                    den_reg        <= r_den;
                    div_second_reg <= 1'b0;
                    state_reg      <= ST_DIV_GO;
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (!div_second_reg && (mode_reg == MODE_ST))
                        begin
                            r0_reg         <= div_quot;
                            div_second_reg <= 1'b1;
                            state_reg      <= ST_DIV_GO;
                        end
                        else
                        begin
                            unique case (mode_reg)
                                MODE_ST:   begin sq_reg <= r0_reg; tq_reg <= div_quot; end
                                MODE_S_T0: begin sq_reg <= div_quot; tq_reg <= '0; end
                                MODE_T_S0: begin sq_reg <= '0; tq_reg <= div_quot; end
                                MODE_S_T1:
                                begin
                                    sq_reg <= div_quot;
                                    tq_reg <= ONE_Q - div_quot;
                                end
                                MODE_T_S1:
                                begin
                                    tq_reg <= div_quot;
                                    sq_reg <= ONE_Q - div_quot;
                                end
                                default:   begin sq_reg <= '0; tq_reg <= '0; end
                            endcase
                            step_reg  <= STEP_NEAR_FIRST;
                            acc_reg   <= '0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_UPDATE:
                begin
                    // Keep the first strictly smaller distance
                    if (dist_reg < best_sq_reg)
                    begin
                        best_sq_reg <= dist_reg;
                        for (int i = 0; i < 3; i++)
                        begin
                            best_pt_reg[i] <= near_reg[i];
                        end
                    end
                    state_reg <= last_reg ? ST_ROOT_GO : ST_IDLE;
                end
                ST_ROOT_GO:
                begin
                    state_reg <= ST_ROOT_WAIT;
                end
                ST_ROOT_WAIT:
                begin
                    if (root_done)
                    begin
                        root_val_reg <= root_out;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            out_pt_reg[i] <= best_pt_reg[i];
                        end
                        out_sq_reg   <= best_sq_reg;
                        out_dist_reg <= root_val_reg;
                        best_sq_reg  <= SQ_MAX;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
